// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the validator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold on a rising clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/cpfv_pkg.sv -----
// package with types, constants and mod-11 helpers for the id check-digit validator
`default_nettype none

package cpfv_pkg;

	localparam int CHAR_W    = 8;
	localparam int POS_W     = 4;
	localparam int RES_W     = 4;
	localparam int VAL_W     = 6;
	localparam int MOD_BASE  = 11;
	localparam int MOD_RECIP = 373;
	localparam int RECIP_SH  = 12;
	localparam int BODY_LEN  = 9;
	localparam int FULL_LEN  = 11;
	localparam int POS_SAT   = 12;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

	typedef struct packed {
		logic              eos;
		logic [CHAR_W-1:0] character;
	} cpfv_item_t;

	// residue mod 11 of a value below 512
	function automatic logic [RES_W-1:0] mod11(input logic [9:0] x);
		logic [18:0] prod;
		logic [5:0]  q;
		logic [9:0]  rem;
		prod = 19'(x) * 19'(MOD_RECIP);
		q    = prod[RECIP_SH+5:RECIP_SH];
		rem  = x - 10'(q) * 10'(MOD_BASE);
		if (rem >= 10'(MOD_BASE)) begin
			rem = rem - 10'(MOD_BASE);
		end
		return rem[RES_W-1:0];
	endfunction

	function automatic logic [RES_W-1:0] check_digit(input logic [RES_W-1:0] r);
		logic [RES_W-1:0] d;
		d = (r > 4'd1) ? 4'(MOD_BASE) - r : 4'd0;
		return d;
	endfunction

	function automatic logic [3:0] weight_first(input logic [POS_W-1:0] pos);
		logic [3:0] w;
		w = 4'(BODY_LEN + 1) - pos;
		return w;
	endfunction

	function automatic logic [3:0] weight_second(input logic [POS_W-1:0] pos);
		logic [3:0] w;
		w = 4'(FULL_LEN) - pos;
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cpfv_core.sv -----
// running residues, class checks and verdict logic of the id check-digit validator
`default_nettype none

module cpfv_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire cpfv_pkg::cpfv_item_t item,
	output logic                     verdict
);
	import cpfv_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [RES_W-1:0]  r1_q;
	logic [RES_W-1:0]  r2_q;
	logic              bad_q;
	logic [3:0]        g1_q;
	logic [3:0]        g2_q;

	logic              is_digit;
	logic              is_upper;
	logic              is_lower;
	logic [CHAR_W-1:0] folded;
	logic [CHAR_W-1:0] offs;
	logic [VAL_W-1:0]  val;
	logic [RES_W-1:0]  r1_next;
	logic [RES_W-1:0]  r2_next;
	logic [RES_W-1:0]  d1;
	logic [RES_W-1:0]  r2_fin;
	logic [RES_W-1:0]  d2;

	always_comb begin
		is_digit = (item.character >= CHAR_ZERO) && (item.character <= CHAR_NINE);
		is_upper = (item.character >= CHAR_UPPER_A) && (item.character <= CHAR_UPPER_Z);
		is_lower = (item.character >= CHAR_LOWER_A) && (item.character <= CHAR_LOWER_Z);
		folded   = is_lower ? item.character - CASE_OFFSET : item.character;
		offs     = folded - CHAR_ZERO;
		val      = offs[VAL_W-1:0];
		r1_next  = mod11(10'(r1_q) + 10'(weight_first(pos_q)) * 10'(val));
		r2_next  = mod11(10'(r2_q) + 10'(weight_second(pos_q)) * 10'(val));
		d1       = check_digit(r1_q);
		r2_fin   = mod11(10'(r2_q) + 10'({d1, 1'b0}));
		d2       = check_digit(r2_fin);
		verdict  = (pos_q == 4'(FULL_LEN)) && !bad_q && (d1 == g1_q) && (d2 == g2_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			r1_q  <= '0;
			r2_q  <= '0;
			bad_q <= 1'b0;
			g1_q  <= '0;
			g2_q  <= '0;
		end else if (step) begin
			if (item.eos) begin
				pos_q <= '0;
				r1_q  <= '0;
				r2_q  <= '0;
				bad_q <= 1'b0;
				g1_q  <= '0;
				g2_q  <= '0;
			end else begin
				if (pos_q < 4'(BODY_LEN)) begin
					if (is_digit || is_upper || is_lower) begin
						r1_q <= r1_next;
						r2_q <= r2_next;
					end else begin
						bad_q <= 1'b1;
					end
				end else if (pos_q < 4'(FULL_LEN)) begin
					if (is_digit) begin
						if (pos_q == 4'(BODY_LEN)) begin
							g1_q <= offs[3:0];
						end else begin
							g2_q <= offs[3:0];
						end
					end else begin
						bad_q <= 1'b1;
					end
				end
				if (pos_q < 4'(POS_SAT)) begin
					pos_q <= pos_q + 4'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/cpf_check_digit_validator.sv -----
// top level of the id check-digit validator with stream handshake
// a terminator transaction passes from the input stage through the output register to m_axis
// throughput: one character or terminator transaction per cycle, set by the single input stage
// unless a stalled verdict holds a terminator in that stage, which then holds back all that follows
// reset: arst_n clears all valid flags, the result, running sums, lengths and flags at once
`default_nettype none
`include "assert_macros.svh"

module cpf_check_digit_validator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] character
	input  wire logic       s_axis_tlast,  // end_of_string
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata   // [0] valid_res, [7:1] zero
);
	import cpfv_pkg::*;

	logic       valid_s1;
	cpfv_item_t item_s1;
	logic       out_valid_q;
	logic       out_res_q;
	logic       adv;
	logic       verdict;

	assign adv           = valid_s1 && (!item_s1.eos || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.eos       <= s_axis_tlast;
			item_s1.character <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_res_q   <= 1'b0;
		end else if (adv && item_s1.eos) begin
			out_valid_q <= 1'b1;
			out_res_q   <= verdict;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	cpfv_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.item    (item_s1),
		.verdict (verdict)
	);

	`ASSERT_CLK(a_eos_stall, valid_s1 && item_s1.eos && out_valid_q && !m_axis_tready |-> !s_axis_tready, "terminator not held while verdict stalled")
	`ASSERT_CLK(a_verdict_out, adv && item_s1.eos |=> m_axis_tvalid, "terminator produced no verdict")
	`ASSERT_CLK(a_stage_load, s_axis_tvalid && s_axis_tready |=> valid_s1, "accepted transaction lost at input stage")
	`ASSERT_NEVER(a_pad_zero, m_axis_tdata[7:1] != 7'd0, "verdict padding not zero")

endmodule

`default_nettype wire
